// ----- src/cau_pkg.sv -----
// Shared widths, codes, side-band type and saturation helper of the complex ALU.
package cau_pkg;

    localparam int DW  = 32;                 // part width
    localparam int FB  = 16;                 // fraction bits
    localparam int PW  = 2 * DW;             // product width
    localparam int SW  = PW + 1;             // sum of two products
    localparam int NW  = SW + FB;            // numerator after fraction shift
    localparam int QB  = DW + 1;             // quotient bits kept
    localparam int CW  = (NW > PW + 1 + QB) ? NW : PW + 1 + QB;
    localparam int LAT = QB + 1;             // divider latency

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_CMP = 3'd4;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DIV0 = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    localparam logic [1:0] MAG_LESS    = 2'd0;
    localparam logic [1:0] MAG_EQUAL   = 2'd1;
    localparam logic [1:0] MAG_GREATER = 2'd2;

    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic          is_div;
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic [1:0]    status;
        logic          neg_re;
        logic          neg_im;
        logic          b_zero;
        logic [1:0]    mag_order;
        logic          a_zero;
    } side_t;

    // {clamped, value}
    function automatic logic [DW:0] sat_fit(input logic signed [SW-1:0] v);
        logic [SW-DW:0] top;
        top = v[SW-1:DW-1];
        if ((&top) || !(|top))
            return {1'b0, v[DW-1:0]};
        else
            return {1'b1, v[SW-1] ? MINV : MAXV};
    endfunction

endpackage

// ----- src/cau_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module cau_div
    import cau_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [PW:0]   den,
    output logic [QB-1:0] quo,
    output logic          ovf
);

    logic [NW-1:0] rem_reg [0:QB];
    logic [PW:0]   den_reg [0:QB];
    logic [QB-1:0] quo_reg [0:QB];
    logic          ovf_reg [0:QB];

    // quotient would need more than QB bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            ovf_reg[0] <= CW'(num) >= (CW'(den) << QB);
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        localparam int SH = QB - k;
        logic [CW-1:0] dsh;
        logic [CW-1:0] rx;
        logic [CW-1:0] diff;
        logic          ge;

        assign dsh  = CW'(den_reg[k-1]) << SH;
        assign rx   = CW'(rem_reg[k-1]);
        assign diff = rx - dsh;
        assign ge   = rx >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[NW-1:0] : rem_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                quo_reg[k] <= quo_reg[k-1] | (ge ? (QB'(1) << SH) : '0);
            end
        end
    end

    assign quo = quo_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

// ----- src/complex_arithmetic_unit.sv -----
// Complex ALU top level: add, subtract, multiply, divide and magnitude compare.
//
//  channel | handshake          | payload
//  input   | in_valid/in_ready  | kind, a_re, a_im, b_re, b_im
//  output  | out_valid/out_ready| res_re, res_im, status, mag_order, a_is_zero
//
// One item per cycle while the output is not stalled; most of the depth is
// the bit-per-stage divider. Every stage advances together whenever the
// output register is empty or being taken; a stall holds all stages.
// Reset clears only the valid bits.
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           kind,
    input  logic signed [DW-1:0] a_re,
    input  logic signed [DW-1:0] a_im,
    input  logic signed [DW-1:0] b_re,
    input  logic signed [DW-1:0] b_im,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [DW-1:0] res_re,
    output logic signed [DW-1:0] res_im,
    output logic [1:0]           status,
    output logic [1:0]           mag_order,
    output logic                 a_is_zero
);

    localparam int NS = 4 + LAT + 1;

    logic          en;
    logic [NS-1:0] vld_reg;

    assign en       = !vld_reg[NS-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-2:0], in_valid};
    end

    // stage 1: operands
    logic [2:0]           kind1_reg;
    logic signed [DW-1:0] ar_reg, ai_reg, br_reg, bi_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg <= kind;
            ar_reg    <= a_re;
            ai_reg    <= a_im;
            br_reg    <= b_re;
            bi_reg    <= b_im;
        end
    end

    // stage 2: products and add/subtract
    logic [2:0]           kind2_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PW-1:0] sq_ar_reg, sq_ai_reg, sq_br_reg, sq_bi_reg;
    logic signed [SW-1:0] as_re_reg, as_im_reg;
    logic                 az2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind2_reg <= kind1_reg;
            p_rr_reg  <= ar_reg * br_reg;
            p_ii_reg  <= ai_reg * bi_reg;
            p_ri_reg  <= ar_reg * bi_reg;
            p_ir_reg  <= ai_reg * br_reg;
            sq_ar_reg <= ar_reg * ar_reg;
            sq_ai_reg <= ai_reg * ai_reg;
            sq_br_reg <= br_reg * br_reg;
            sq_bi_reg <= bi_reg * bi_reg;
            as_re_reg <= (kind1_reg == KIND_SUB) ? SW'(ar_reg) - SW'(br_reg)
                                                 : SW'(ar_reg) + SW'(br_reg);
            as_im_reg <= (kind1_reg == KIND_SUB) ? SW'(ai_reg) - SW'(bi_reg)
                                                 : SW'(ai_reg) + SW'(bi_reg);
            az2_reg   <= (ar_reg == '0) && (ai_reg == '0);
        end
    end

    // stage 3: combine products
    logic [2:0]           kind3_reg;
    logic signed [SW-1:0] pr_reg, pi_reg, nr_reg, ni_reg;
    logic signed [SW-1:0] as_re3_reg, as_im3_reg;
    logic [PW:0]          maga_reg, magb_reg;
    logic                 az3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind3_reg  <= kind2_reg;
            pr_reg     <= SW'(p_rr_reg) - SW'(p_ii_reg);
            pi_reg     <= SW'(p_ri_reg) + SW'(p_ir_reg);
            nr_reg     <= SW'(p_rr_reg) + SW'(p_ii_reg);
            ni_reg     <= SW'(p_ir_reg) - SW'(p_ri_reg);
            maga_reg   <= (PW+1)'($unsigned(sq_ar_reg)) + (PW+1)'($unsigned(sq_ai_reg));
            magb_reg   <= (PW+1)'($unsigned(sq_br_reg)) + (PW+1)'($unsigned(sq_bi_reg));
            as_re3_reg <= as_re_reg;
            as_im3_reg <= as_im_reg;
            az3_reg    <= az2_reg;
        end
    end

    // stage 4: saturate add, subtract and multiply results, prepare the divider
    side_t                side_next;
    logic signed [NW-1:0] nsh_re, nsh_im;
    logic [NW-1:0]        nmag_re_next, nmag_im_next;
    logic [DW:0]          fit_re, fit_im;

    always_comb
    begin
        nsh_re       = NW'(nr_reg) <<< FB;
        nsh_im       = NW'(ni_reg) <<< FB;
        nmag_re_next = nsh_re[NW-1] ? NW'(-nsh_re) : NW'(nsh_re);
        nmag_im_next = nsh_im[NW-1] ? NW'(-nsh_im) : NW'(nsh_im);

        if (kind3_reg == KIND_MUL)
        begin
            fit_re = sat_fit(pr_reg >>> FB);
            fit_im = sat_fit(pi_reg >>> FB);
        end
        else
        begin
            fit_re = sat_fit(as_re3_reg);
            fit_im = sat_fit(as_im3_reg);
        end

        side_next           = '0;
        side_next.is_div    = (kind3_reg == KIND_DIV);
        side_next.neg_re    = nsh_re[NW-1];
        side_next.neg_im    = nsh_im[NW-1];
        side_next.b_zero    = (magb_reg == '0);
        side_next.a_zero    = az3_reg;
        side_next.mag_order = (maga_reg < magb_reg)  ? MAG_LESS :
                              (maga_reg == magb_reg) ? MAG_EQUAL : MAG_GREATER;
        if ((kind3_reg == KIND_ADD) || (kind3_reg == KIND_SUB) || (kind3_reg == KIND_MUL))
        begin
            side_next.re     = fit_re[DW-1:0];
            side_next.im     = fit_im[DW-1:0];
            side_next.status = (fit_re[DW] || fit_im[DW]) ? STATUS_SAT : STATUS_OK;
        end
    end

    side_t         side4_reg;
    logic [NW-1:0] nmag_re_reg, nmag_im_reg;
    logic [PW:0]   den_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side4_reg   <= side_next;
            nmag_re_reg <= nmag_re_next;
            nmag_im_reg <= nmag_im_next;
            den_reg     <= magb_reg;
        end
    end

    // divider stages; side band follows alongside
    logic [QB-1:0] q_re, q_im;
    logic          ovf_re, ovf_im;

    cau_div u_div_re
    (
        .clk (clk),
        .en  (en),
        .num (nmag_re_reg),
        .den (den_reg),
        .quo (q_re),
        .ovf (ovf_re)
    );

    cau_div u_div_im
    (
        .clk (clk),
        .en  (en),
        .num (nmag_im_reg),
        .den (den_reg),
        .quo (q_im),
        .ovf (ovf_im)
    );

    side_t side_reg [0:LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side4_reg;
            for (int i = 1; i < LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // output register
    side_t       sd;
    logic [DW:0] dfit_re, dfit_im;
    logic [DW-1:0] re_next, im_next;
    logic [1:0]  st_next;
    logic        dsat_re, dsat_im;

    always_comb
    begin
        sd      = side_reg[LAT-1];
        dfit_re = sat_fit(sd.neg_re ? -SW'(q_re) : SW'(q_re));
        dfit_im = sat_fit(sd.neg_im ? -SW'(q_im) : SW'(q_im));
        dsat_re = ovf_re || dfit_re[DW];
        dsat_im = ovf_im || dfit_im[DW];
        re_next = sd.re;
        im_next = sd.im;
        st_next = sd.status;
        if (sd.is_div)
        begin
            if (sd.b_zero)
            begin
                re_next = '0;
                im_next = '0;
                st_next = STATUS_DIV0;
            end
            else
            begin
                re_next = ovf_re ? (sd.neg_re ? MINV : MAXV) : dfit_re[DW-1:0];
                im_next = ovf_im ? (sd.neg_im ? MINV : MAXV) : dfit_im[DW-1:0];
                st_next = (dsat_re || dsat_im) ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    logic [DW-1:0] res_re_reg, res_im_reg;
    logic [1:0]    status_reg, mag_reg;
    logic          az_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg <= re_next;
            res_im_reg <= im_next;
            status_reg <= st_next;
            mag_reg    <= sd.mag_order;
            az_reg     <= sd.a_zero;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign status    = status_reg;
    assign mag_order = mag_reg;
    assign a_is_zero = az_reg;

    a_div0_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_DIV0) |-> (res_re == '0) && (res_im == '0))
        else $error("divide by zero with non-zero result");

    a_sat_bound : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_SAT) |->
            (res_re == MAXV) || (res_re == MINV) || (res_im == MAXV) || (res_im == MINV))
        else $error("saturated status without a clamped part");

    a_ready : assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready disagrees with pipeline advance");

endmodule
